// ===== rtl/core/aspp_pkg.sv =====
// Package for the audio sample payload packer: sizes, codes and state type.
// No dependencies; imported by aspp_duty and the top level.
package aspp_pkg;

  localparam int PAYLOAD_BYTES     = 32;
  localparam int ADDR_W            = $clog2(PAYLOAD_BYTES);
  localparam int BYTE_W            = 8;
  localparam int SAMPLE_W          = 10;
  localparam int DUTY_W            = 16;
  localparam int SHIFT_W           = 5;
  localparam int COUNT_W           = ADDR_W + 1;

  localparam logic [COUNT_W-1:0] TEN_BIT_SAMPLES   = COUNT_W'(25);
  localparam logic [COUNT_W-1:0] EIGHT_BIT_SAMPLES = COUNT_W'(PAYLOAD_BYTES);
  localparam logic [ADDR_W-1:0]  HIGH_AREA_START   = ADDR_W'(25);
  localparam logic [ADDR_W-1:0]  LAST_BYTE         = ADDR_W'(PAYLOAD_BYTES - 1);

  localparam logic [1:0] CFG_TEN_BIT_MODE   = 2'd0;
  localparam logic [1:0] CFG_VOLUME_SHIFT   = 2'd1;
  localparam logic [1:0] CFG_MONITOR_ENABLE = 2'd2;

  localparam logic KIND_DUTY = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HB_RD,
    ST_HB_WR,
    ST_DUTY,
    ST_DUMP
  } aspp_state_t;

endpackage

// ===== rtl/core/aspp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while rd_en is low. No dependencies.
module aspp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== rtl/core/aspp_duty.sv =====
// Speaker duty value: monitored sample shifted by the signed volume setting.
// Depends on aspp_pkg.
module aspp_duty
  import aspp_pkg::*;
(
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                ten_bit,
  input  logic [SHIFT_W-1:0]  shift,
  output logic [DUTY_W-1:0]   duty
);

  logic [DUTY_W-1:0]  mon;
  logic [SHIFT_W-1:0] mag;

  always_comb begin
    mon = ten_bit ? DUTY_W'(sample) : DUTY_W'(sample[SAMPLE_W-1:2]);
    mag = SHIFT_W'(-shift);
    if (shift[SHIFT_W-1]) begin
      duty = mon >> mag;
    end else begin
      duty = mon << shift[SHIFT_W-2:0];
    end
  end

endmodule

// ===== rtl/core/audio_sample_payload_packer.sv =====
// Top level of the audio sample payload packer: control, frame store, output register.
// Depends on aspp_pkg, aspp_ram and aspp_duty.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tdata[9:0] adc_sample
//  out_    | out | out_tvalid/out_tready | tdata value, byte index; tuser kind; tlast
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item at a time: IDLE writes the sample; 10-bit mode adds HB_RD and HB_WR
// (read-modify-write of the high-bit byte via the single read port); DUTY sends the
// duty value; DUMP streams a full payload, one byte per cycle when out_tready is high.
// Reset is synchronous; the store reads as zero until written (per-entry valid bits).
// Output stalls hold the output register and the store read data.
module audio_sample_payload_packer
  import aspp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] adc_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] result_value, [20:16] byte_index
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast,  // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  aspp_state_t state_r, state_nxt;

  logic                ten_bit_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic                mon_en_r;

  logic [COUNT_W-1:0]  count_r;
  logic [ADDR_W-1:0]   hb_r;
  logic [1:0]          pair_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic                full_r;

  logic [PAYLOAD_BYTES-1:0] vld_r;
  logic                     rd_vld_r;
  logic [COUNT_W-1:0]       rd_idx_r;
  logic                     pend_r;
  logic [ADDR_W-1:0]        pend_idx_r;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [DUTY_W-1:0]   out_value_r;
  logic [ADDR_W-1:0]   out_idx_r;
  logic                out_last_r;

  logic                accept;
  logic [SAMPLE_W-1:0] in_smp;
  logic [COUNT_W-1:0]  count_inc;
  logic                full_now;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   ram_rd;
  logic [BYTE_W-1:0]   rd_byte;
  logic [BYTE_W-1:0]   hb_new;
  logic [BYTE_W-1:0]   dump_byte;
  logic [DUTY_W-1:0]   duty;
  logic                slot_free;
  logic                load_duty;
  logic                load_byte;
  logic                issue;

  assign cfg_ready = 1'b1;
  assign in_smp    = in_tdata[SAMPLE_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign count_inc = count_r + COUNT_W'(1);
  assign full_now  = ten_bit_r ? (count_inc >= TEN_BIT_SAMPLES)
                               : (count_inc >= EIGHT_BIT_SAMPLES);
  assign slot_free = !out_valid_r || out_tready;
  assign rd_byte   = rd_vld_r ? ram_rd : '0;

  assign issue     = (state_r == ST_DUMP) && !rd_idx_r[ADDR_W] && (!pend_r || load_byte);
  assign load_byte = (state_r == ST_DUMP) && pend_r && slot_free;

  aspp_duty u_duty (
    .sample  (smp_r),
    .ten_bit (ten_bit_r),
    .shift   (shift_r),
    .duty    (duty)
  );

  aspp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  always_comb begin
    hb_new = rd_byte;
    unique case (pair_r)
      2'd0: hb_new[1:0] = smp_r[9:8];
      2'd1: hb_new[3:2] = smp_r[9:8];
      2'd2: hb_new[5:4] = smp_r[9:8];
      2'd3: hb_new[7:6] = smp_r[9:8];
      default: hb_new = rd_byte;
    endcase
  end

  always_comb begin
    dump_byte = rd_byte;
    if (ten_bit_r && pend_idx_r == LAST_BYTE) begin
      dump_byte = rd_byte & BYTE_W'(3);
    end
  end

  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_addr   = count_r[ADDR_W-1:0];
    wr_data   = ten_bit_r ? in_smp[BYTE_W-1:0] : in_smp[SAMPLE_W-1:2];
    rd_en     = 1'b0;
    rd_addr   = rd_idx_r[ADDR_W-1:0];
    load_duty = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          wr_en     = 1'b1;
          state_nxt = ten_bit_r ? ST_HB_RD : ST_DUTY;
        end
      end
      ST_HB_RD: begin
        rd_en     = 1'b1;
        rd_addr   = hb_r;
        state_nxt = ST_HB_WR;
      end
      ST_HB_WR: begin
        wr_en     = 1'b1;
        wr_addr   = hb_r;
        wr_data   = hb_new;
        state_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        if (!mon_en_r || slot_free) begin
          load_duty = mon_en_r;
          state_nxt = full_r ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DUMP: begin
        rd_en = issue;
        if (rd_idx_r[ADDR_W] && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ten_bit_r <= 1'b1;
      shift_r   <= SHIFT_W'(2);
      mon_en_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        CFG_TEN_BIT_MODE:   ten_bit_r <= cfg_data[0];
        CFG_VOLUME_SHIFT:   shift_r   <= cfg_data;
        CFG_MONITOR_ENABLE: mon_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hb_r    <= HIGH_AREA_START;
      pair_r  <= '0;
      full_r  <= 1'b0;
    end else begin
      if (accept) begin
        full_r  <= full_now;
        count_r <= full_now ? '0 : count_inc;
        if (!ten_bit_r && full_now) begin
          hb_r   <= HIGH_AREA_START;
          pair_r <= '0;
        end
      end
      if (state_r == ST_HB_WR) begin
        if (full_r) begin
          hb_r   <= HIGH_AREA_START;
          pair_r <= '0;
        end else begin
          pair_r <= pair_r + 2'd1;
          if (pair_r == 2'd3) begin
            hb_r <= hb_r + ADDR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r <= in_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      pend_r     <= 1'b0;
      pend_idx_r <= '0;
    end else begin
      if (state_r == ST_DUTY) begin
        rd_idx_r <= '0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + COUNT_W'(1);
      end
      if (issue) begin
        pend_r     <= 1'b1;
        pend_idx_r <= rd_idx_r[ADDR_W-1:0];
      end else if (load_byte) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_duty || load_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_duty) begin
      out_kind_r  <= KIND_DUTY;
      out_value_r <= duty;
      out_idx_r   <= '0;
      out_last_r  <= 1'b0;
    end else if (load_byte) begin
      out_kind_r  <= KIND_BYTE;
      out_value_r <= DUTY_W'(dump_byte);
      out_idx_r   <= pend_idx_r;
      out_last_r  <= (pend_idx_r == LAST_BYTE);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_idx_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
